// ----- sv/pwd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwd_pkg: shared types and constants of the proximity wear detector
// Field widths, register map, wear codes and the control and status
// bundles passed between the detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pwd_pkg;

   // default sizes of the window, warm-up and count field
   localparam int DEF_WINDOW_DEPTH = 200;
   localparam int DEF_WARMUP_TICKS = 400;
   localparam int DEF_COUNT_BITS   = 16;

   // field widths
   localparam int IN_BITS     = 16;
   localparam int SUM_BITS    = 24;
   localparam int FRAC_BITS   = 16;
   localparam int LEVEL_BITS  = SUM_BITS + FRAC_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int MARGIN_BITS = 16;
   localparam int PROD_BITS   = LEVEL_BITS + WEIGHT_BITS;
   localparam int WARM_BITS   = 9;

   localparam logic [WARM_BITS-1:0] WARM_MAX = '1;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_POWER_ON_LEVEL = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MARGIN         = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FAST_WEIGHT    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_WEIGHT    = 2'd3;

   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET      = 16'd175;
   localparam logic [WEIGHT_BITS-1:0] FAST_WEIGHT_RESET = 16'd16384;
   localparam logic [WEIGHT_BITS-1:0] SLOW_WEIGHT_RESET = 16'd3277;

   // wear codes
   localparam logic [1:0] WEAR_UNDECIDED = 2'd0;
   localparam logic [1:0] WEAR_WORN      = 2'd1;
   localparam logic [1:0] WEAR_NOT_WORN  = 2'd2;

   // strobes that walk one average update through its stages
   typedef struct packed {
      logic load;    // take the window sum and form the difference
      logic step;    // multiply the difference by the weight
      logic commit;  // accumulate into the level
   } ema_ctl_type;

   // decision state presented on the result channel
   typedef struct packed {
      logic [1:0]            wear_code;
      logic                  indicator;
      logic                  ready;
      logic                  free_running;
      logic [LEVEL_BITS-1:0] on_level;
      logic [LEVEL_BITS-1:0] off_level;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/pwd_ram.sv -----
// ----------------------------------------------------------------------------
// pwd_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 200,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/pwd_window.sv -----
// ----------------------------------------------------------------------------
// pwd_window: moving window of pulse counts and its running sum
// Read the oldest count when an item is taken, retire it and store the new
// count in the following cycle while the sum is updated.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_window #(
   parameter int WINDOW_DEPTH = pwd_pkg::DEF_WINDOW_DEPTH,
   parameter int COUNT_BITS   = pwd_pkg::DEF_COUNT_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         w_vld,
   input  wire logic [pwd_pkg::IN_BITS-1:0]  pulse_count,
   output logic      [pwd_pkg::SUM_BITS-1:0] total
);
   import pwd_pkg::*;

   localparam int XW    = (COUNT_BITS < IN_BITS) ? COUNT_BITS : IN_BITS;
   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic                wrapped_ff, wrapped_in;
   logic [PTR_W-1:0]    w_ptr_ff;
   logic [XW-1:0]       w_x_ff;
   logic                w_old_ok_ff;
   logic [SUM_BITS-1:0] total_ff, total_in;
   logic [XW-1:0]       old_count;
   logic [XW-1:0]       rd_count;

   pwd_ram #(
      .WIDTH (XW),
      .DEPTH (WINDOW_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (w_vld),
      .waddr (w_ptr_ff),
      .wdata (w_x_ff),
      .re    (accept),
      .raddr (ptr_ff),
      .rdata (rd_count)
   );

   // an entry is only real once the pointer has gone round the window
   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (ptr_ff == PTR_LAST) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   assign old_count = w_old_ok_ff ? rd_count : '0;
   assign total_in  = w_vld ? (total_ff - SUM_BITS'(old_count) + SUM_BITS'(w_x_ff))
                            : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
         total_ff   <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         w_ptr_ff    <= ptr_ff;
         w_x_ff      <= pulse_count[XW-1:0];
         w_old_ok_ff <= wrapped_ff;
      end
   end

   assign total = total_ff;

endmodule

`default_nettype wire

// ----- sv/pwd_ema.sv -----
// ----------------------------------------------------------------------------
// pwd_ema: one exponential average in Q24.16
// Difference, weight product and floored accumulate, one register apart.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_ema (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pwd_pkg::ema_ctl_type            ctl,
   input  wire logic [pwd_pkg::LEVEL_BITS-1:0]  sumq,
   input  wire logic [pwd_pkg::WEIGHT_BITS-1:0] weight,
   output logic      [pwd_pkg::LEVEL_BITS-1:0]  level
);
   import pwd_pkg::*;

   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [LEVEL_BITS-1:0] p_diff_ff;
   logic                  p_ge_ff;
   logic [PROD_BITS-1:0]  u_prod_ff;
   logic                  u_ge_ff;
   logic                  ge;
   logic [LEVEL_BITS-1:0] mag;
   logic                  round_up;

   assign ge = (sumq >= level_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         p_ge_ff   <= ge;
         p_diff_ff <= ge ? (sumq - level_ff) : (level_ff - sumq);
      end
      if (ctl.step) begin
         u_ge_ff   <= p_ge_ff;
         u_prod_ff <= PROD_BITS'(p_diff_ff) * PROD_BITS'(weight);
      end
   end

   // floor toward minus infinity: a falling step rounds its magnitude up
   assign mag      = u_prod_ff[PROD_BITS-1:FRAC_BITS];
   assign round_up = ~u_ge_ff & (|u_prod_ff[FRAC_BITS-1:0]);
   assign level_in = u_ge_ff ? (level_ff + mag)
                             : (level_ff - mag - LEVEL_BITS'(round_up));

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (ctl.commit) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

// ----- sv/pwd_decide.sv -----
// ----------------------------------------------------------------------------
// pwd_decide: warm-up tracking and wear decision
// Power-on compare against the stored level, then hysteresis on the
// fast-slow difference with level capture at each transition.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_decide #(
   parameter int WARMUP_TICKS = pwd_pkg::DEF_WARMUP_TICKS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic [pwd_pkg::LEVEL_BITS-1:0]  fast,
   input  wire logic [pwd_pkg::LEVEL_BITS-1:0]  slow,
   input  wire logic [pwd_pkg::LEVEL_BITS-1:0]  power_on_level,
   input  wire logic [pwd_pkg::MARGIN_BITS-1:0] margin,
   output pwd_pkg::status_type                  status
);
   import pwd_pkg::*;

   localparam int EW = LEVEL_BITS + 1;
   localparam logic [WARM_BITS-1:0] WARM_DONE = WARM_BITS'(WARMUP_TICKS);

   logic [WARM_BITS-1:0]  warm_ff, warm_in;
   logic                  ready_ff, ready_in;
   logic                  mode_ff, mode_in;
   logic [1:0]            wear_ff, wear_in;
   logic                  pin_ff, pin_in;
   logic [LEVEL_BITS-1:0] con_ff, con_in;
   logic [LEVEL_BITS-1:0] coff_ff, coff_in;
   logic signed [EW-1:0]  err;
   logic signed [EW-1:0]  pos_m;
   logic signed [EW-1:0]  neg_m;
   logic                  gt;
   logic                  lt;

   assign err   = $signed({1'b0, fast}) - $signed({1'b0, slow});
   assign pos_m = $signed(EW'({margin, {FRAC_BITS{1'b0}}}));
   assign neg_m = -pos_m;
   assign gt    = (err > pos_m);
   assign lt    = (err < neg_m);

   always_comb begin
      warm_in  = warm_ff;
      ready_in = ready_ff;
      mode_in  = mode_ff;
      wear_in  = wear_ff;
      con_in   = con_ff;
      coff_in  = coff_ff;
      pin_in   = pin_ff;

      if (!ready_ff) begin
         if (warm_ff >= WARM_DONE) begin
            ready_in = 1'b1;
         end
         if (warm_ff != WARM_MAX) begin
            warm_in = warm_ff + 1'b1;
         end
      end

      if (!mode_ff) begin
         if (ready_in) begin
            if (power_on_level > fast) begin
               wear_in = WEAR_WORN;
            end else begin
               mode_in = 1'b1;
               wear_in = WEAR_NOT_WORN;
            end
            if (gt && wear_in != WEAR_NOT_WORN) begin
               wear_in = WEAR_NOT_WORN;
               mode_in = 1'b1;
            end
         end
      end else begin
         if (lt && wear_ff != WEAR_WORN) begin
            wear_in = WEAR_WORN;
            con_in  = fast;
         end
         if (gt && wear_in != WEAR_NOT_WORN) begin
            wear_in = WEAR_NOT_WORN;
            coff_in = fast;
         end
      end

      priority if (wear_in == WEAR_WORN) begin
         pin_in = 1'b1;
      end else if (wear_in == WEAR_NOT_WORN) begin
         pin_in = 1'b0;
      end else begin
         pin_in = pin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff  <= '0;
         ready_ff <= 1'b0;
         mode_ff  <= 1'b0;
         wear_ff  <= WEAR_UNDECIDED;
         pin_ff   <= 1'b0;
         con_ff   <= '0;
         coff_ff  <= '0;
      end else if (fire) begin
         warm_ff  <= warm_in;
         ready_ff <= ready_in;
         mode_ff  <= mode_in;
         wear_ff  <= wear_in;
         pin_ff   <= pin_in;
         con_ff   <= con_in;
         coff_ff  <= coff_in;
      end
   end

   always_comb begin
      status.wear_code    = wear_ff;
      status.indicator    = pin_ff;
      status.ready        = ready_ff;
      status.free_running = mode_ff;
      status.on_level     = con_ff;
      status.off_level    = coff_ff;
   end

endmodule

`default_nettype wire

// ----- sv/proximity_wear_detector_core.sv -----
// ----------------------------------------------------------------------------
// proximity_wear_detector_core: wear detection from oscillator pulse counts
// Moving window sum, fast and slow Q24.16 averages, warm-up and a
// hysteresis wear decision, with a register port for the power-on level, margin and weights.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload
//   --------  ---------------------------  -------------------------------
//   req       req_valid / req_stall        req_pulse_count
//   rsp       rsp_valid / rsp_stall        wear_code, indicator, ready_res,
//                                          free_running, window_sum,
//                                          fast_avg, slow_avg, on_level,
//                                          off_level
//   csr       psel/penable/pwrite/pready   paddr, pwdata, prdata (64 bits)
//
// Overlap: a new item can be taken while the last is still in the average
//   loop; that loop (difference, weight multiply, accumulate, each
//   registered) sets the pace. A result reaches rsp_valid through W, D, P, U, V.
// Reset: synchronous, active high; no clearing pass. Window entries read as
//   zero until the write pointer first wraps.
// Stalls: rsp_stall holds the output register; the item behind it waits in
//   the pipeline and req_stall stays high while the D stage holds its item.
// ----------------------------------------------------------------------------
`default_nettype none

module proximity_wear_detector_core #(
   parameter int WINDOW_DEPTH = pwd_pkg::DEF_WINDOW_DEPTH,
   parameter int WARMUP_TICKS = pwd_pkg::DEF_WARMUP_TICKS,
   parameter int COUNT_BITS   = pwd_pkg::DEF_COUNT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pwd_pkg::IN_BITS-1:0]       req_pulse_count,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [1:0]                        rsp_wear_code,
   output logic                                   rsp_indicator,
   output logic                                   rsp_ready_res,
   output logic                                   rsp_free_running,
   output logic      [pwd_pkg::SUM_BITS-1:0]      rsp_window_sum,
   output logic      [pwd_pkg::LEVEL_BITS-1:0]    rsp_fast_avg,
   output logic      [pwd_pkg::LEVEL_BITS-1:0]    rsp_slow_avg,
   output logic      [pwd_pkg::LEVEL_BITS-1:0]    rsp_on_level,
   output logic      [pwd_pkg::LEVEL_BITS-1:0]    rsp_off_level,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pwd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [pwd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [pwd_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);
   import pwd_pkg::*;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [LEVEL_BITS-1:0]   pol_ff;
   logic [MARGIN_BITS-1:0]  margin_ff;
   logic [WEIGHT_BITS-1:0]  fw_ff;
   logic [WEIGHT_BITS-1:0]  sw_ff;
   logic                    csr_wr;
   logic [CSR_IDX_BITS-1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_ADDR_BITS-1:CSR_ADDR_BITS-CSR_IDX_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_ff    <= '0;
         margin_ff <= MARGIN_RESET;
         fw_ff     <= FAST_WEIGHT_RESET;
         sw_ff     <= SLOW_WEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_POWER_ON_LEVEL: pol_ff    <= pwdata[LEVEL_BITS-1:0];
            REG_MARGIN:         margin_ff <= pwdata[MARGIN_BITS-1:0];
            REG_FAST_WEIGHT:    fw_ff     <= pwdata[WEIGHT_BITS-1:0];
            REG_SLOW_WEIGHT:    sw_ff     <= pwdata[WEIGHT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_POWER_ON_LEVEL: prdata = CSR_DATA_BITS'(pol_ff);
         REG_MARGIN:         prdata = CSR_DATA_BITS'(margin_ff);
         REG_FAST_WEIGHT:    prdata = CSR_DATA_BITS'(fw_ff);
         REG_SLOW_WEIGHT:    prdata = CSR_DATA_BITS'(sw_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline occupancy
   //   W: window read data back, sum update, count written
   //   D: averages form their differences against the current levels
   //   P: weight products
   //   U: levels accumulate
   //   V: decision, result register loads
   // ------------------------------------------------------------------
   logic w_vld_ff, w_vld_in;
   logic d_vld_ff, d_vld_in;
   logic p_vld_ff, p_vld_in;
   logic u_vld_ff, u_vld_in;
   logic v_vld_ff, v_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic accept;
   logic d_go;
   logic u_go;
   logic v_go;

   // take an item only when W and D are clear, so W never waits
   assign req_stall = w_vld_ff | d_vld_ff;
   assign accept    = req_valid & ~req_stall;

   // hold D until the previous update has left the average loop
   assign d_go = d_vld_ff & ~p_vld_ff & ~u_vld_ff;
   assign v_go = v_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign u_go = u_vld_ff & (~v_vld_ff | v_go);

   always_comb begin
      w_vld_in   = accept;
      d_vld_in   = w_vld_ff | (d_vld_ff & ~d_go);
      p_vld_in   = d_go;
      u_vld_in   = p_vld_ff | (u_vld_ff & ~u_go);
      v_vld_in   = u_go | (v_vld_ff & ~v_go);
      rsp_vld_in = v_go | (rsp_vld_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         p_vld_ff   <= 1'b0;
         u_vld_ff   <= 1'b0;
         v_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         w_vld_ff   <= w_vld_in;
         d_vld_ff   <= d_vld_in;
         p_vld_ff   <= p_vld_in;
         u_vld_ff   <= u_vld_in;
         v_vld_ff   <= v_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Window memory and sum
   // ------------------------------------------------------------------
   logic [SUM_BITS-1:0] total;

   pwd_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .COUNT_BITS   (COUNT_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .w_vld       (w_vld_ff),
      .pulse_count (req_pulse_count),
      .total       (total)
   );

   // carry the sum along beside the averages for the result
   logic [SUM_BITS-1:0] p_sum_ff;
   logic [SUM_BITS-1:0] u_sum_ff;
   logic [SUM_BITS-1:0] v_sum_ff;

   always_ff @(posedge clock) begin
      if (d_go) begin
         p_sum_ff <= total;
      end
      if (p_vld_ff) begin
         u_sum_ff <= p_sum_ff;
      end
      if (u_go) begin
         v_sum_ff <= u_sum_ff;
      end
   end

   // ------------------------------------------------------------------
   // Fast and slow averages
   // ------------------------------------------------------------------
   ema_ctl_type           ema_ctl;
   logic [LEVEL_BITS-1:0] sumq;
   logic [LEVEL_BITS-1:0] fast_level;
   logic [LEVEL_BITS-1:0] slow_level;

   assign sumq = {total, {FRAC_BITS{1'b0}}};

   always_comb begin
      ema_ctl.load   = d_go;
      ema_ctl.step   = p_vld_ff;
      ema_ctl.commit = u_go;
   end

   pwd_ema u_fast (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ema_ctl),
      .sumq   (sumq),
      .weight (fw_ff),
      .level  (fast_level)
   );

   pwd_ema u_slow (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ema_ctl),
      .sumq   (sumq),
      .weight (sw_ff),
      .level  (slow_level)
   );

   // ------------------------------------------------------------------
   // Decision; its state doubles as the status part of the result, as
   // it only advances when a result loads
   // ------------------------------------------------------------------
   status_type status;

   pwd_decide #(
      .WARMUP_TICKS (WARMUP_TICKS)
   ) u_decide (
      .clock          (clock),
      .reset          (reset),
      .fire           (v_go),
      .fast           (fast_level),
      .slow           (slow_level),
      .power_on_level (pol_ff),
      .margin         (margin_ff),
      .status         (status)
   );

   // ------------------------------------------------------------------
   // Result register: levels move on with the next item, so latch them
   // ------------------------------------------------------------------
   logic [SUM_BITS-1:0]   rsp_sum_ff;
   logic [LEVEL_BITS-1:0] rsp_fast_ff;
   logic [LEVEL_BITS-1:0] rsp_slow_ff;

   always_ff @(posedge clock) begin
      if (v_go) begin
         rsp_sum_ff  <= v_sum_ff;
         rsp_fast_ff <= fast_level;
         rsp_slow_ff <= slow_level;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_wear_code    = status.wear_code;
   assign rsp_indicator    = status.indicator;
   assign rsp_ready_res    = status.ready;
   assign rsp_free_running = status.free_running;
   assign rsp_window_sum   = rsp_sum_ff;
   assign rsp_fast_avg     = rsp_fast_ff;
   assign rsp_slow_avg     = rsp_slow_ff;
   assign rsp_on_level     = status.on_level;
   assign rsp_off_level    = status.off_level;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // only one update may be inside the average loop
   assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> !u_vld_ff)
      else $error("two items inside the average loop");

   // window stage never waits: W always hands its item on to D
   assert property (@(posedge clock) disable iff (reset)
      w_vld_ff |=> d_vld_ff && !w_vld_ff)
      else $error("window stage did not hand over");

   // warm-up complete never clears outside reset
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(status.ready))
      else $error("ready flag dropped");

endmodule

`default_nettype wire
